>>> sv/homography_bbox_mapper_macros.svh
// assertion macros for the homography box mapper
`ifndef HOMOGRAPHY_BBOX_MAPPER_MACROS_SVH
`define HOMOGRAPHY_BBOX_MAPPER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define HBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define HBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/hbm_pkg.sv
// shared constants, types and rounding helper for the homography box mapper
package hbm_pkg;
	localparam int COEF_W    = 48;
	localparam int PIX_W     = 12;
	localparam int CRD_W     = PIX_W + 1;
	localparam int PROD_W    = COEF_W + CRD_W + 1;
	localparam int SUM_W     = PROD_W + 1;
	localparam int MAG_W     = SUM_W - 1;
	localparam int QB        = 12;
	localparam int RES_W     = QB + 2;
	localparam int IR_W      = 11;
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;
	localparam int IR_WIDTH  = 160;
	localparam int IR_HEIGHT = 120;
	localparam int SAT_LO    = -2048;
	localparam int SAT_HI    = 2047;
	localparam logic signed [COEF_W-1:0] ONE_Q32 = 48'sh0001_0000_0000;
	localparam logic [1:0] LAST_CORNER = 2'd3;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef enum logic [2:0] {
		REG_X_FROM_X, REG_X_FROM_Y, REG_X_OFFSET,
		REG_Y_FROM_X, REG_Y_FROM_Y, REG_Y_OFFSET,
		REG_PERSP_FROM_X, REG_PERSP_FROM_Y
	} reg_idx_t;

	typedef struct packed {
		coef_t x_from_x;
		coef_t x_from_y;
		coef_t x_offset;
		coef_t y_from_x;
		coef_t y_from_y;
		coef_t y_offset;
		coef_t persp_from_x;
		coef_t persp_from_y;
	} hmat_t;

	typedef struct packed {
		logic first;
		logic last;
		logic dz;
		logic neg_x;
		logic neg_y;
	} ctag_t;

	typedef struct packed {
		logic             vld;
		ctag_t            tag;
		logic [MAG_W-1:0] den;
		logic [MAG_W-1:0] rem_x;
		logic [MAG_W-1:0] rem_y;
		logic [QB-1:0]    q_x;
		logic [QB-1:0]    q_y;
		logic             ovf_x;
		logic             ovf_y;
	} dstage_t;

	typedef struct packed {
		logic          vld;
		ctag_t         tag;
		logic [QB-1:0] q_x;
		logic [QB-1:0] q_y;
		logic          ovf_x;
		logic          ovf_y;
		logic          rnz_x;
		logic          rnz_y;
	} dres_t;

	// floor (up low) or ceiling (up high) from truncated magnitude quotient, saturated
	function automatic logic signed [RES_W-1:0] round_q(logic [QB-1:0] q, logic ovf,
			logic rnz, logic neg, logic up);
		logic signed [RES_W-1:0] m;
		logic signed [RES_W-1:0] r;
		m = signed'({2'b00, q});
		if (!neg) begin
			r = m + RES_W'(up && rnz);
			if (ovf || r > SAT_HI) r = RES_W'(SAT_HI);
		end else begin
			r = -m - RES_W'(!up && rnz);
			if (ovf || r < SAT_LO) r = RES_W'(SAT_LO);
		end
		return r;
	endfunction
endpackage

>>> sv/hbm_corner.sv
// corner sequencer and projective numerator / denominator pipeline
`include "homography_bbox_mapper_macros.svh"
module hbm_corner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hbm_pkg::PIX_W-1:0]     vis_x,
	input  logic [hbm_pkg::PIX_W-1:0]     vis_y,
	input  logic [hbm_pkg::PIX_W-1:0]     vis_width,
	input  logic [hbm_pkg::PIX_W-1:0]     vis_height,
	input  hbm_pkg::hmat_t                hmat,
	output hbm_pkg::dstage_t              corner_out
);
	logic                          busy_q;
	logic [1:0]                    cnt_q;
	logic [hbm_pkg::PIX_W-1:0]     x_q, y_q, w_q, h_q;
	logic                          vld_s1, first_s1, last_s1;
	logic [hbm_pkg::CRD_W-1:0]     u_s1, v_s1;
	logic                          vld_s2, first_s2, last_s2;
	logic signed [hbm_pkg::PROD_W-1:0] pxu_s2, pxv_s2, pyu_s2, pyv_s2, pdu_s2, pdv_s2;
	logic                          vld_s3, first_s3, last_s3;
	logic signed [hbm_pkg::SUM_W-1:0] nx_s3, ny_s3, d_s3;
	logic signed [hbm_pkg::SUM_W-1:0] nx_abs, ny_abs, d_abs;
	logic signed [hbm_pkg::CRD_W:0]   us, vs;
	logic                          accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = adv && (!busy_q || cnt_q == hbm_pkg::LAST_CORNER);

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= vis_x;
			y_q <= vis_y;
			w_q <= vis_width;
			h_q <= vis_height;
		end
	end

	// corner walk: top-left, top-right, bottom-right, bottom-left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == hbm_pkg::LAST_CORNER) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= (cnt_q == 2'd0);
			last_s1  <= (cnt_q == hbm_pkg::LAST_CORNER);
			u_s1     <= (cnt_q[0] ^ cnt_q[1]) ? ({1'b0, x_q} + {1'b0, w_q}) : {1'b0, x_q};
			v_s1     <= cnt_q[1] ? ({1'b0, y_q} + {1'b0, h_q}) : {1'b0, y_q};
		end
	end

	// products
	assign us = signed'({1'b0, u_s1});
	assign vs = signed'({1'b0, v_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			pxu_s2   <= hmat.x_from_x * us;
			pxv_s2   <= hmat.x_from_y * vs;
			pyu_s2   <= hmat.y_from_x * us;
			pyv_s2   <= hmat.y_from_y * vs;
			pdu_s2   <= hmat.persp_from_x * us;
			pdv_s2   <= hmat.persp_from_y * vs;
		end
	end

	// sums
	always_ff @(posedge clk) begin
		if (adv) begin
			first_s3 <= first_s2;
			last_s3  <= last_s2;
			nx_s3    <= hbm_pkg::SUM_W'(pxu_s2) + hbm_pkg::SUM_W'(pxv_s2)
				+ hbm_pkg::SUM_W'(hmat.x_offset);
			ny_s3    <= hbm_pkg::SUM_W'(pyu_s2) + hbm_pkg::SUM_W'(pyv_s2)
				+ hbm_pkg::SUM_W'(hmat.y_offset);
			d_s3     <= hbm_pkg::SUM_W'(pdu_s2) + hbm_pkg::SUM_W'(pdv_s2)
				+ hbm_pkg::SUM_W'(hbm_pkg::ONE_Q32);
		end
	end

	// magnitudes and signs for the divider
	assign nx_abs = nx_s3[hbm_pkg::SUM_W-1] ? -nx_s3 : nx_s3;
	assign ny_abs = ny_s3[hbm_pkg::SUM_W-1] ? -ny_s3 : ny_s3;
	assign d_abs  = d_s3[hbm_pkg::SUM_W-1] ? -d_s3 : d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_out <= '0;
		end else if (adv) begin
			corner_out.vld       <= vld_s3;
			corner_out.tag.first <= first_s3;
			corner_out.tag.last  <= last_s3;
			corner_out.tag.dz    <= (d_s3 == '0);
			corner_out.tag.neg_x <= nx_s3[hbm_pkg::SUM_W-1] ^ d_s3[hbm_pkg::SUM_W-1];
			corner_out.tag.neg_y <= ny_s3[hbm_pkg::SUM_W-1] ^ d_s3[hbm_pkg::SUM_W-1];
			corner_out.den       <= d_abs[hbm_pkg::MAG_W-1:0];
			corner_out.rem_x     <= nx_abs[hbm_pkg::MAG_W-1:0];
			corner_out.rem_y     <= ny_abs[hbm_pkg::MAG_W-1:0];
			corner_out.q_x       <= '0;
			corner_out.q_y       <= '0;
			corner_out.ovf_x     <= 1'b0;
			corner_out.ovf_y     <= 1'b0;
		end
	end

	`HBM_ASSERT_NXT(a_load_starts_walk, clk, arst_n, accept, busy_q && cnt_q == 2'd0, "walk did not restart on request")
	`HBM_ASSERT_IMP(a_walk_marks, clk, arst_n, vld_s1 && last_s1, !first_s1, "corner marks clash")
endmodule

>>> sv/hbm_div.sv
// pipelined restoring divider pair, one quotient bit per stage
module hbm_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  hbm_pkg::dstage_t div_in,
	output hbm_pkg::dres_t   div_out
);
	localparam int CW = hbm_pkg::MAG_W + hbm_pkg::QB;

	hbm_pkg::dstage_t div_s [0:hbm_pkg::QB];
	hbm_pkg::dstage_t nxt   [1:hbm_pkg::QB];
	logic [CW-1:0]    lim;

	// overflow check: quotient would need more than QB bits
	assign lim = {div_in.den, {hbm_pkg::QB{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0] <= '0;
		end else if (adv) begin
			div_s[0].vld   <= div_in.vld;
			div_s[0].tag   <= div_in.tag;
			div_s[0].den   <= div_in.den;
			div_s[0].rem_x <= div_in.rem_x;
			div_s[0].rem_y <= div_in.rem_y;
			div_s[0].q_x   <= '0;
			div_s[0].q_y   <= '0;
			div_s[0].ovf_x <= {{hbm_pkg::QB{1'b0}}, div_in.rem_x} >= lim;
			div_s[0].ovf_y <= {{hbm_pkg::QB{1'b0}}, div_in.rem_y} >= lim;
		end
	end

	// quotient bit stages, most significant first
	for (genvar j = 1; j <= hbm_pkg::QB; j++) begin : g_bit
		localparam int K = hbm_pkg::QB - j;
		logic [CW-1:0] sh;
		logic          ge_x, ge_y;

		always_comb begin
			sh   = {{hbm_pkg::QB{1'b0}}, div_s[j-1].den} << K;
			ge_x = {{hbm_pkg::QB{1'b0}}, div_s[j-1].rem_x} >= sh;
			ge_y = {{hbm_pkg::QB{1'b0}}, div_s[j-1].rem_y} >= sh;
			nxt[j] = div_s[j-1];
			if (ge_x) nxt[j].rem_x = div_s[j-1].rem_x - sh[hbm_pkg::MAG_W-1:0];
			if (ge_y) nxt[j].rem_y = div_s[j-1].rem_y - sh[hbm_pkg::MAG_W-1:0];
			nxt[j].q_x[K] = ge_x;
			nxt[j].q_y[K] = ge_y;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[j] <= '0;
			end else if (adv) begin
				div_s[j] <= nxt[j];
			end
		end
	end

	// quotient and remainder flags
	assign div_out.vld   = div_s[hbm_pkg::QB].vld;
	assign div_out.tag   = div_s[hbm_pkg::QB].tag;
	assign div_out.q_x   = div_s[hbm_pkg::QB].q_x;
	assign div_out.q_y   = div_s[hbm_pkg::QB].q_y;
	assign div_out.ovf_x = div_s[hbm_pkg::QB].ovf_x;
	assign div_out.ovf_y = div_s[hbm_pkg::QB].ovf_y;
	assign div_out.rnz_x = div_s[hbm_pkg::QB].rem_x != '0;
	assign div_out.rnz_y = div_s[hbm_pkg::QB].rem_y != '0;
endmodule

>>> sv/hbm_box.sv
// floor / ceiling, bounding box over four corners, clamp and output register
module hbm_box (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  hbm_pkg::dres_t            div_out,
	output logic                      out_valid,
	output logic                      box_valid,
	output logic [hbm_pkg::IR_W-1:0]  ir_x,
	output logic [hbm_pkg::IR_W-1:0]  ir_y,
	output logic [hbm_pkg::IR_W-1:0]  ir_wd,
	output logic [hbm_pkg::IR_W-1:0]  ir_ht
);
	logic                                 vld_s18, first_s18, last_s18;
	logic signed [hbm_pkg::RES_W-1:0]     fx_s18, cx_s18, fy_s18, cy_s18;
	logic signed [hbm_pkg::RES_W-1:0]     xmin_q, xmax_q, ymin_q, ymax_q;
	logic signed [hbm_pkg::RES_W-1:0]     xmin_n, xmax_n, ymin_n, ymax_n;
	logic [hbm_pkg::IR_W-1:0]             x1, x2, y1, y2;
	logic signed [hbm_pkg::IR_W:0]        bw, bh;
	logic                                 ok;

	function automatic logic [hbm_pkg::IR_W-1:0] clamp_to(
			logic signed [hbm_pkg::RES_W-1:0] v, int hi);
		logic [hbm_pkg::IR_W-1:0] r;
		if (v < 0) r = '0;
		else if (v > hi) r = hbm_pkg::IR_W'(hi);
		else r = v[hbm_pkg::IR_W-1:0];
		return r;
	endfunction

	// floor and ceiling per corner, zero denominator maps to the origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s18 <= 1'b0;
		end else if (adv) begin
			vld_s18 <= div_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s18 <= div_out.tag.first;
			last_s18  <= div_out.tag.last;
			if (div_out.tag.dz) begin
				fx_s18 <= '0;
				cx_s18 <= '0;
				fy_s18 <= '0;
				cy_s18 <= '0;
			end else begin
				fx_s18 <= hbm_pkg::round_q(div_out.q_x, div_out.ovf_x, div_out.rnz_x,
					div_out.tag.neg_x, 1'b0);
				cx_s18 <= hbm_pkg::round_q(div_out.q_x, div_out.ovf_x, div_out.rnz_x,
					div_out.tag.neg_x, 1'b1);
				fy_s18 <= hbm_pkg::round_q(div_out.q_y, div_out.ovf_y, div_out.rnz_y,
					div_out.tag.neg_y, 1'b0);
				cy_s18 <= hbm_pkg::round_q(div_out.q_y, div_out.ovf_y, div_out.rnz_y,
					div_out.tag.neg_y, 1'b1);
			end
		end
	end

	// running extremes, first corner restarts them
	always_comb begin
		xmin_n = (first_s18 || fx_s18 < xmin_q) ? fx_s18 : xmin_q;
		xmax_n = (first_s18 || cx_s18 > xmax_q) ? cx_s18 : xmax_q;
		ymin_n = (first_s18 || fy_s18 < ymin_q) ? fy_s18 : ymin_q;
		ymax_n = (first_s18 || cy_s18 > ymax_q) ? cy_s18 : ymax_q;
		x1 = clamp_to(xmin_n, hbm_pkg::IR_WIDTH);
		x2 = clamp_to(xmax_n, hbm_pkg::IR_WIDTH);
		y1 = clamp_to(ymin_n, hbm_pkg::IR_HEIGHT);
		y2 = clamp_to(ymax_n, hbm_pkg::IR_HEIGHT);
		bw = signed'({1'b0, x2}) - signed'({1'b0, x1});
		bh = signed'({1'b0, y2}) - signed'({1'b0, y1});
		ok = (bw > 0) && (bh > 0);
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s18) begin
			xmin_q <= xmin_n;
			xmax_q <= xmax_n;
			ymin_q <= ymin_n;
			ymax_q <= ymax_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s18 && last_s18;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s18 && last_s18) begin
			box_valid <= ok;
			ir_x      <= ok ? x1 : '0;
			ir_y      <= ok ? y1 : '0;
			ir_wd     <= ok ? bw[hbm_pkg::IR_W-1:0] : '0;
			ir_ht     <= ok ? bh[hbm_pkg::IR_W-1:0] : '0;
		end
	end
endmodule

>>> sv/homography_bbox_mapper.sv
// top level: configuration registers and the box mapping pipeline
// Usage
//   Input request: in_valid / in_ready with vis_x, vis_y, vis_width, vis_height.
//   Result: out_valid / out_ready with box_valid, ir_x, ir_y, ir_wd, ir_ht.
//   Eight homography coefficients sit on an APB-style port, 64-bit data,
//   register i at byte address 8*i, sign-extended on read; write only while idle.
// Flow
//   A request's four corners go one per cycle, unless the pipeline holds,
//   through a single projective datapath and one pipelined divider pair;
//   the next request is accepted while the last corner is being issued.
// Pipeline
//   After the walk over the remaining corners, the last corner passes 4 corner
//   stages, 13 divider stages (overflow check plus one quotient bit each),
//   rounding, and the bounding-box merge into the output register.
// Reset
//   Coefficients return to the identity, the pipeline empties; no sweep.
// Stall
//   While out_valid is high and out_ready low the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated.
`include "homography_bbox_mapper_macros.svh"
module homography_bbox_mapper (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hbm_pkg::ADDR_W-1:0]     paddr,
	input  logic [hbm_pkg::DATA_W-1:0]     pwdata,
	output logic [hbm_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [hbm_pkg::PIX_W-1:0]      vis_x,
	input  logic [hbm_pkg::PIX_W-1:0]      vis_y,
	input  logic [hbm_pkg::PIX_W-1:0]      vis_width,
	input  logic [hbm_pkg::PIX_W-1:0]      vis_height,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           box_valid,
	output logic [hbm_pkg::IR_W-1:0]       ir_x,
	output logic [hbm_pkg::IR_W-1:0]       ir_y,
	output logic [hbm_pkg::IR_W-1:0]       ir_wd,
	output logic [hbm_pkg::IR_W-1:0]       ir_ht
);
	hbm_pkg::hmat_t    hmat_q;
	hbm_pkg::reg_idx_t idx;
	hbm_pkg::coef_t    rd;
	hbm_pkg::coef_t    wcoef;
	hbm_pkg::dstage_t  corner_out;
	hbm_pkg::dres_t    div_out;
	logic              adv;

	assign pready = 1'b1;
	assign idx    = hbm_pkg::reg_idx_t'(paddr[hbm_pkg::ADDR_W-1:3]);
	assign wcoef  = pwdata[hbm_pkg::COEF_W-1:0];

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmat_q              <= '0;
			hmat_q.x_from_x     <= hbm_pkg::ONE_Q32;
			hmat_q.y_from_y     <= hbm_pkg::ONE_Q32;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				hbm_pkg::REG_X_FROM_X:     hmat_q.x_from_x     <= wcoef;
				hbm_pkg::REG_X_FROM_Y:     hmat_q.x_from_y     <= wcoef;
				hbm_pkg::REG_X_OFFSET:     hmat_q.x_offset     <= wcoef;
				hbm_pkg::REG_Y_FROM_X:     hmat_q.y_from_x     <= wcoef;
				hbm_pkg::REG_Y_FROM_Y:     hmat_q.y_from_y     <= wcoef;
				hbm_pkg::REG_Y_OFFSET:     hmat_q.y_offset     <= wcoef;
				hbm_pkg::REG_PERSP_FROM_X: hmat_q.persp_from_x <= wcoef;
				hbm_pkg::REG_PERSP_FROM_Y: hmat_q.persp_from_y <= wcoef;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			hbm_pkg::REG_X_FROM_X:     rd = hmat_q.x_from_x;
			hbm_pkg::REG_X_FROM_Y:     rd = hmat_q.x_from_y;
			hbm_pkg::REG_X_OFFSET:     rd = hmat_q.x_offset;
			hbm_pkg::REG_Y_FROM_X:     rd = hmat_q.y_from_x;
			hbm_pkg::REG_Y_FROM_Y:     rd = hmat_q.y_from_y;
			hbm_pkg::REG_Y_OFFSET:     rd = hmat_q.y_offset;
			hbm_pkg::REG_PERSP_FROM_X: rd = hmat_q.persp_from_x;
			hbm_pkg::REG_PERSP_FROM_Y: rd = hmat_q.persp_from_y;
			default:                   rd = '0;
		endcase
	end
	assign prdata = {{(hbm_pkg::DATA_W - hbm_pkg::COEF_W){rd[hbm_pkg::COEF_W-1]}}, rd};

	// whole pipeline moves unless a result is stuck
	assign adv = !out_valid || out_ready;

	hbm_corner u_corner (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.vis_x      (vis_x),
		.vis_y      (vis_y),
		.vis_width  (vis_width),
		.vis_height (vis_height),
		.hmat       (hmat_q),
		.corner_out (corner_out)
	);

	hbm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.div_in  (corner_out),
		.div_out (div_out)
	);

	hbm_box u_box (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.div_out   (div_out),
		.out_valid (out_valid),
		.box_valid (box_valid),
		.ir_x      (ir_x),
		.ir_y      (ir_y),
		.ir_wd     (ir_wd),
		.ir_ht     (ir_ht)
	);

	`HBM_ASSERT_IMP(a_empty_is_zero, clk, arst_n, out_valid && !box_valid, ir_x == 11'd0 && ir_y == 11'd0 && ir_wd == 11'd0 && ir_ht == 11'd0, "empty box not zeroed")
	`HBM_ASSERT_IMP(a_box_in_frame, clk, arst_n, out_valid && box_valid, ir_wd != 11'd0 && ir_ht != 11'd0 && 12'(ir_x) + 12'(ir_wd) <= 12'(hbm_pkg::IR_WIDTH) && 12'(ir_y) + 12'(ir_ht) <= 12'(hbm_pkg::IR_HEIGHT), "box outside IR frame")
endmodule

>>> dv/tb.sv
// self-checking testbench for the homography box mapper
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic [hbm_pkg::PIX_W-1:0] x, y, w, h;
	} vis_rect_t;

	typedef struct {
		logic                     ok;
		logic [hbm_pkg::IR_W-1:0] x, y, w, h;
	} ir_box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [hbm_pkg::ADDR_W-1:0] paddr = '0;
	logic [hbm_pkg::DATA_W-1:0] pwdata = '0;
	logic [hbm_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic [hbm_pkg::PIX_W-1:0] vis_x = '0, vis_y = '0, vis_width = '0, vis_height = '0;
	logic out_valid, out_ready = 1'b0;
	logic box_valid;
	logic [hbm_pkg::IR_W-1:0] ir_x, ir_y, ir_wd, ir_ht;

	hbm_pkg::coef_t hmat [8];
	vis_rect_t      pending_rects [$];
	ir_box_t        expected_boxes [$];
	int             req_gap, resp_stall, quiet_cycles;
	int             n_req, n_resp, n_valid_boxes, n_mismatch;
	bit             no_idle;

	homography_bbox_mapper i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// floor or ceiling of an exact signed quotient, saturated
	function automatic longint div_round(longint n, longint d, bit up);
		longint q, r;
		q = n / d;
		r = n % d;
		if (r != 0 && !up && ((r < 0) != (d < 0))) q--;
		if (r != 0 && up && ((r < 0) == (d < 0))) q++;
		if (q < hbm_pkg::SAT_LO) q = hbm_pkg::SAT_LO;
		if (q > hbm_pkg::SAT_HI) q = hbm_pkg::SAT_HI;
		return q;
	endfunction

	function automatic longint clamp_ir(longint v, longint hi);
		return (v < 0) ? 0 : (v > hi) ? hi : v;
	endfunction

	// project the four corners and take the clamped bounding box
	function automatic ir_box_t project_rect(vis_rect_t r);
		longint u [4], v [4];
		longint nx, ny, d, fx, cx, fy, cy, xmin, xmax, ymin, ymax, x1, x2, y1, y2;
		ir_box_t b;
		u[0] = r.x;       v[0] = r.y;
		u[1] = r.x + r.w; v[1] = r.y;
		u[2] = r.x + r.w; v[2] = r.y + r.h;
		u[3] = r.x;       v[3] = r.y + r.h;
		for (int k = 0; k < 4; k++) begin
			nx = hmat[hbm_pkg::REG_X_FROM_X] * u[k] + hmat[hbm_pkg::REG_X_FROM_Y] * v[k]
				+ hmat[hbm_pkg::REG_X_OFFSET];
			ny = hmat[hbm_pkg::REG_Y_FROM_X] * u[k] + hmat[hbm_pkg::REG_Y_FROM_Y] * v[k]
				+ hmat[hbm_pkg::REG_Y_OFFSET];
			d = hmat[hbm_pkg::REG_PERSP_FROM_X] * u[k] + hmat[hbm_pkg::REG_PERSP_FROM_Y] * v[k]
				+ longint'(hbm_pkg::ONE_Q32);
			if (d == 0) begin
				fx = 0; cx = 0; fy = 0; cy = 0;
			end else begin
				fx = div_round(nx, d, 0);
				cx = div_round(nx, d, 1);
				fy = div_round(ny, d, 0);
				cy = div_round(ny, d, 1);
			end
			if (k == 0 || fx < xmin) xmin = fx;
			if (k == 0 || cx > xmax) xmax = cx;
			if (k == 0 || fy < ymin) ymin = fy;
			if (k == 0 || cy > ymax) ymax = cy;
		end
		x1 = clamp_ir(xmin, hbm_pkg::IR_WIDTH);
		x2 = clamp_ir(xmax, hbm_pkg::IR_WIDTH);
		y1 = clamp_ir(ymin, hbm_pkg::IR_HEIGHT);
		y2 = clamp_ir(ymax, hbm_pkg::IR_HEIGHT);
		b = '{1'b0, '0, '0, '0, '0};
		if (x2 - x1 > 0 && y2 - y1 > 0)
			b = '{1'b1, hbm_pkg::IR_W'(x1), hbm_pkg::IR_W'(y1), hbm_pkg::IR_W'(x2 - x1),
				hbm_pkg::IR_W'(y2 - y1)};
		return b;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		vis_rect_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_gap  <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_boxes.push_back(project_rect('{vis_x, vis_y, vis_width, vis_height}));
				n_req++;
			end
			if (!in_valid || in_ready) begin
				if (req_gap != 0) begin
					req_gap  <= req_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_rects.size() != 0) begin
					r = pending_rects.pop_front();
					vis_x      <= r.x;
					vis_y      <= r.y;
					vis_width  <= r.w;
					vis_height <= r.h;
					in_valid   <= 1'b1;
					req_gap    <= no_idle ? 0 : $urandom_range(0, 13);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		ir_box_t e;
		int s;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			resp_stall <= 0;
		end else if (out_valid && out_ready) begin
			n_resp++;
			if (expected_boxes.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("unexpected result at %0t", $realtime);
			end else begin
				e = expected_boxes.pop_front();
				if (e.ok) n_valid_boxes++;
				if (box_valid !== e.ok || ir_x !== e.x || ir_y !== e.y
						|| ir_wd !== e.w || ir_ht !== e.h) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch at %0t: exp %b %0d %0d %0d %0d got %b %0d %0d %0d %0d",
							$realtime, e.ok, e.x, e.y, e.w, e.h,
							box_valid, ir_x, ir_y, ir_wd, ir_ht);
				end
			end
			s = no_idle ? 0 : $urandom_range(0, 13);
			resp_stall <= s;
			out_ready  <= (s == 0);
		end else if (resp_stall != 0) begin
			resp_stall <= resp_stall - 1;
			out_ready  <= (resp_stall == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog on stalled progress
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (pending_rects.size() == 0 && expected_boxes.size() == 0))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic write_coef(hbm_pkg::reg_idx_t idx, hbm_pkg::coef_t c);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= hbm_pkg::ADDR_W'(8 * int'(idx));
		pwdata  <= {{(hbm_pkg::DATA_W - hbm_pkg::COEF_W){c[hbm_pkg::COEF_W-1]}}, c};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		hmat[idx] = c;
	endtask

	task automatic wait_idle();
		while (pending_rects.size() != 0 || expected_boxes.size() != 0 || in_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// signed random coefficient with magnitude below 2^bits
	function automatic hbm_pkg::coef_t rand_coef(int bits);
		longint m;
		m = {$urandom, $urandom};
		m = m & ((longint'(1) << bits) - 1);
		return hbm_pkg::coef_t'($urandom_range(0, 1) ? -m : m);
	endfunction

	task automatic add_rect(int x, int y, int w, int h);
		pending_rects.push_back('{hbm_pkg::PIX_W'(x), hbm_pkg::PIX_W'(y),
			hbm_pkg::PIX_W'(w), hbm_pkg::PIX_W'(h)});
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0)
				add_rect($urandom, $urandom, $urandom, $urandom);
			else
				add_rect($urandom_range(0, 300), $urandom_range(0, 300),
					$urandom_range(0, 200), $urandom_range(0, 200));
		end
	endtask

	task automatic load_matrix(hbm_pkg::coef_t c [8]);
		for (int i = 0; i < 8; i++) write_coef(hbm_pkg::reg_idx_t'(i), c[i]);
	endtask

	initial begin
		hbm_pkg::coef_t m [8];
		hbm_pkg::coef_t pmax, pmin;
		pmax = {1'b0, {(hbm_pkg::COEF_W - 1){1'b1}}};
		pmin = {1'b1, {(hbm_pkg::COEF_W - 1){1'b0}}};
		foreach (hmat[i]) hmat[i] = '0;
		hmat[hbm_pkg::REG_X_FROM_X] = hbm_pkg::ONE_Q32;
		hmat[hbm_pkg::REG_Y_FROM_Y] = hbm_pkg::ONE_Q32;
		no_idle = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// identity after reset: field extremes and empty boxes
		add_rect(0, 0, 0, 0);
		add_rect(4095, 4095, 4095, 4095);
		add_rect(0, 0, 4095, 4095);
		add_rect(10, 20, 30, 40);
		add_rect(159, 119, 1, 1);
		add_rect(160, 0, 5, 5);
		add_rect(0, 120, 5, 5);
		add_rect(100, 50, 0, 10);
		add_rect(2730, 1365, 1365, 2730);
		add_random(40);
		wait_idle();

		// downscale with offsets, no idling on either side
		no_idle = 1'b1;
		m = '{hbm_pkg::coef_t'(longint'(1) << 28), hbm_pkg::coef_t'(longint'(1) << 24),
			-(hbm_pkg::coef_t'(3) <<< 32), -(hbm_pkg::coef_t'(1) <<< 24),
			hbm_pkg::coef_t'(longint'(1) << 28), hbm_pkg::coef_t'(5) <<< 32,
			hbm_pkg::coef_t'(longint'(1) << 18), -(hbm_pkg::coef_t'(1) <<< 18)};
		load_matrix(m);
		add_random(300);
		wait_idle();
		no_idle = 1'b0;

		// coefficient extremes
		m = '{pmax, pmax, pmax, pmax, pmax, pmax, pmax, pmax};
		load_matrix(m);
		add_random(100);
		wait_idle();
		m = '{pmin, pmin, pmin, pmin, pmin, pmin, pmin, pmin};
		load_matrix(m);
		add_random(100);
		wait_idle();

		// zero denominator: persp -1.0 makes u = 1, v = 0 divide by zero
		m = '{hbm_pkg::ONE_Q32, 0, hbm_pkg::coef_t'(7) <<< 32, 0, hbm_pkg::ONE_Q32,
			hbm_pkg::coef_t'(9) <<< 32, -hbm_pkg::ONE_Q32, 0};
		load_matrix(m);
		add_rect(1, 0, 0, 0);
		add_rect(1, 0, 3, 4);
		add_rect(0, 0, 1, 2);
		add_rect(1, 5, 0, 6);
		add_random(60);
		wait_idle();

		// random perspective matrices, mostly moderate, some unbounded
		for (int p = 0; p < 12; p++) begin
			for (int i = 0; i < 8; i++)
				m[i] = (p % 4 == 3) ? rand_coef(47)
					: rand_coef((i == 2 || i == 5) ? 40 : (i >= 6) ? 22 : 32);
			load_matrix(m);
			add_random(120);
			wait_idle();
		end

		$display("%0d requests sent, %0d results checked over 17 coefficient sets,",
			n_req, n_resp);
		$display("%0d non-empty boxes, saturating extremes and zero denominators; %0d mismatches",
			n_valid_boxes, n_mismatch);
		if (n_mismatch == 0 && expected_boxes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
